/* hw/rtl/ueb_pkg.sv */
// Package for the encoder and button event unit: widths, codes, types, tables.
// No dependencies.
package ueb_pkg;

  localparam int unsigned QueueDepth = 8;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned NumButtons = 3;
  localparam int unsigned BtnAw      = $clog2(NumButtons);
  localparam int unsigned CfgAw      = 2;
  localparam int unsigned CfgDw      = 16;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_SERVICE = 2'd1,
    CMD_POLL    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_SELECT = 2'd0,
    KIND_BACK   = 2'd1,
    KIND_HOME   = 2'd2,
    KIND_ROTATE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_REVERSE  = 2'd2,
    REG_CPD      = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BTN,
    ST_ENC,
    ST_DIV,
    ST_POLL
  } state_e;

  localparam logic [1:0] NoButton  = 2'd3;
  localparam logic [1:0] BackId    = 2'd2;

  typedef struct packed {
    logic        stable;
    logic        flicker;
    logic [31:0] change_time;
    logic [31:0] press_time;
    logic        pressed;
    logic        long_done;
  } btn_t;

  localparam btn_t BtnReset = '{stable: 1'b1, flicker: 1'b1, change_time: '0,
                                press_time: '0, pressed: 1'b0, long_done: 1'b0};

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  steps;
  } event_t;

  function automatic logic signed [1:0] step_lut(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: s = -2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sd1;
      default: s = 2'sd0;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/ueb_if.sv */
// Handshake interfaces for input items, result items and register writes.
// Depends on ueb_pkg.
interface ueb_in_if import ueb_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        enc_a;
  logic        enc_b;
  logic [31:0] now_ms;
  logic        push_level;
  logic        confirm_level;
  logic        back_level;
  modport source (output valid, command, enc_a, enc_b, now_ms, push_level, confirm_level,
                  back_level, input ready);
  modport sink (input valid, command, enc_a, enc_b, now_ms, push_level, confirm_level,
                back_level, output ready);
endinterface

interface ueb_out_if ();
  logic              valid;
  logic              ready;
  logic              event_valid;
  logic [1:0]        event_kind;
  logic signed [7:0] event_steps;
  modport source (output valid, event_valid, event_kind, event_steps, input ready);
  modport sink (input valid, event_valid, event_kind, event_steps, output ready);
endinterface

interface ueb_cfg_if import ueb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CfgAw-1:0] index;
  logic [CfgDw-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/ueb_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ueb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* hw/rtl/ueb_div.sv */
// Restoring divider, one quotient bit per cycle: 17-bit magnitude by 5-bit divisor.
// Depends on ueb_pkg.
module ueb_div import ueb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] dividend_i,
  input  logic [4:0]  divisor_i,
  output logic        done_o,
  output logic [16:0] quot_o,
  output logic [4:0]  rem_o
);
  logic [16:0] quot_q, quot_d;
  logic [4:0]  rem_q, rem_d;
  logic [4:0]  dsr_q, dsr_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [5:0]  shifted;

  assign shifted = {rem_q, quot_q[16]};

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dsr_q}) begin
        rem_d = 5'(shifted - {1'b0, dsr_q});
        quot_d = {quot_q[15:0], 1'b1};
      end else begin
        rem_d = shifted[4:0];
        quot_d = {quot_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule

/* hw/rtl/ui_encoder_button_event_unit.sv */
// Top level of the encoder and button event unit: sequencer, button state RAM,
// event ring RAM and detent divider. Depends on ueb_pkg, ueb_if, ueb_ram, ueb_div.
//
// Usage:
//   in_ch carries items: command 0 samples encoder pins A/B, command 1 is the
//   millisecond service tick with raw active-low button levels, command 2 polls
//   one event, command 3 does nothing. Only polls produce a result on out_ch.
//   cfg_ch writes the four registers (debounce, long press, reversal, counts
//   per detent); it is always ready. The user must see that it is written only
//   while the block is idle; the block itself does not enforce this. A sample
//   is handled in the idle state; a service tick makes three read-modify-write
//   passes over the button state RAM, then the encoder step and, when no button
//   is held, the detent divider; a poll reads the event RAM into the output register.
//   One item is worked on at a time; in_ch.ready is high when the sequencer
//   is free.
//   The result sits in an output register, so the next item is accepted while
//   it waits; a second poll waits until the first result is taken.
//   Reset: registers take their defaults, buttons read as released through
//   per-entry valid bits, the event ring is empty; no clearing pass.
module ui_encoder_button_event_unit import ueb_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  ueb_in_if.sink    in_ch,
  ueb_out_if.source out_ch,
  ueb_cfg_if.sink   cfg_ch
);
  // configuration
  logic [15:0] deb_q, lp_q;
  logic        rev_q;
  logic [4:0]  cpd_q;

  state_e state_q, state_d;
  logic [BtnAw-1:0] idx_q, idx_d;
  logic [31:0] now_q;
  logic [2:0]  lvl_q;
  logic [1:0]  prev_q, prev_d;
  logic signed [15:0] count_q, count_d;
  logic signed [15:0] resid_q, resid_d;
  logic [1:0]  active_q, active_d;
  logic [NumButtons-1:0] bvld_q, bvld_d;
  logic [QueueAw-1:0] head_q, head_d, tail_q, tail_d, head_nx, tail_nx;
  logic        neg_q, neg_d;

  logic        out_vq, out_vd, out_ev_q, out_ev_d;
  kind_e       out_kind_q, out_kind_d;
  logic [7:0]  out_steps_q, out_steps_d;

  logic in_fire, out_load, q_full, q_empty;

  // RAM ports
  logic btn_we;
  btn_t btn_rd, btn_raw, btn_wr;
  logic [$bits(btn_t)-1:0] btn_rdata;
  logic ev_we;
  event_t ev_wr, ev_rd;
  logic [$bits(event_t)-1:0] ev_rdata;

  // divider
  logic        div_start, div_done;
  logic [16:0] div_dvd, div_q;
  logic [4:0]  div_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q <= 16'd30;
      lp_q  <= 16'd1000;
      rev_q <= 1'b0;
      cpd_q <= 5'd4;
    end else if (cfg_ch.valid) begin
      case (reg_e'(cfg_ch.index))
        REG_DEBOUNCE: deb_q <= cfg_ch.data;
        REG_LONG:     lp_q  <= cfg_ch.data;
        REG_REVERSE:  rev_q <= cfg_ch.data[0];
        REG_CPD:      cpd_q <= cfg_ch.data[4:0];
        default: ;
      endcase
    end
  end

  ueb_ram #(.Width($bits(btn_t)), .Depth(NumButtons)) u_btn_ram (
    .clk_i, .we_i(btn_we), .waddr_i(idx_q), .wdata_i(btn_wr),
    .raddr_i(idx_d), .rdata_o(btn_rdata)
  );
  assign btn_raw = btn_t'(btn_rdata);
  assign btn_rd  = bvld_q[idx_q] ? btn_raw : BtnReset;

  ueb_ram #(.Width($bits(event_t)), .Depth(QueueDepth)) u_ev_ram (
    .clk_i, .we_i(ev_we), .waddr_i(head_q), .wdata_i(ev_wr),
    .raddr_i(tail_q), .rdata_o(ev_rdata)
  );
  assign ev_rd = event_t'(ev_rdata);

  ueb_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dvd),
    .divisor_i((cpd_q == 5'd0) ? 5'd1 : cpd_q),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );

  assign head_nx = (head_q == QueueAw'(QueueDepth - 1)) ? '0 : head_q + 1'b1;
  assign tail_nx = (tail_q == QueueAw'(QueueDepth - 1)) ? '0 : tail_q + 1'b1;
  assign q_full  = (head_nx == tail_q);
  assign q_empty = (head_q == tail_q);

  assign in_ch.ready = (state_q == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_q == ST_POLL) && (!out_vq || out_ch.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire && cmd_e'(in_ch.command) == CMD_SERVICE) state_d = ST_BTN;
        else if (in_fire && cmd_e'(in_ch.command) == CMD_POLL) state_d = ST_POLL;
      end
      ST_BTN:  if (idx_q == BtnAw'(NumButtons - 1)) state_d = ST_ENC;
      ST_ENC:  state_d = (active_q != NoButton) ? ST_IDLE : ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_IDLE;
      ST_POLL: if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  logic [3:0]  stp_idx;
  logic signed [16:0] cnt_sum, taken;
  logic signed [17:0] res_sum;
  logic        lvl, isp, wp, is_back;
  logic [31:0] age_ct, age_pt;
  logic [16:0] mag;
  logic [7:0]  clamp_mag;

  always_comb begin
    prev_d = prev_q;
    count_d = count_q;
    resid_d = resid_q;
    active_d = active_q;
    bvld_d = bvld_q;
    idx_d = '0;
    head_d = head_q;
    tail_d = tail_q;
    neg_d = neg_q;
    btn_we = 1'b0;
    btn_wr = btn_rd;
    ev_we = 1'b0;
    ev_wr = '{kind: KIND_SELECT, steps: 8'd0};
    div_start = 1'b0;
    div_dvd = '0;
    out_vd = out_vq;
    out_ev_d = out_ev_q;
    out_kind_d = out_kind_q;
    out_steps_d = out_steps_q;
    stp_idx = {prev_q, in_ch.enc_a, in_ch.enc_b};
    cnt_sum = 17'(count_q) + 17'(step_lut(stp_idx));
    lvl = lvl_q[idx_q];
    is_back = (2'(idx_q) == BackId);
    age_ct = '0;
    age_pt = now_q - btn_rd.press_time;
    isp = 1'b0;
    wp = btn_rd.pressed;
    taken = rev_q ? -17'(count_q) : 17'(count_q);
    res_sum = 18'(resid_q) + 18'(taken);
    mag = '0;
    clamp_mag = '0;

    if (out_vq && out_ch.ready) out_vd = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire && cmd_e'(in_ch.command) == CMD_SAMPLE) begin
          if (cnt_sum > 17'sd32767) count_d = 16'sd32767;
          else if (cnt_sum < -17'sd32768) count_d = -16'sd32768;
          else count_d = 16'(cnt_sum);
          prev_d = {in_ch.enc_a, in_ch.enc_b};
        end
      end
      ST_BTN: begin
        idx_d = idx_q + 1'b1;
        btn_we = 1'b1;
        bvld_d[idx_q] = 1'b1;
        if (lvl != btn_rd.flicker) begin
          btn_wr.flicker = lvl;
          btn_wr.change_time = now_q;
        end
        age_ct = now_q - btn_wr.change_time;
        if (age_ct >= 32'(deb_q)) btn_wr.stable = btn_wr.flicker;
        isp = !btn_wr.stable;
        if (isp && !wp) begin
          if (active_q == NoButton) begin
            active_d = 2'(idx_q);
            btn_wr.press_time = now_q;
            btn_wr.pressed = 1'b1;
            btn_wr.long_done = 1'b0;
          end
        end else if (isp && wp && active_q == 2'(idx_q)) begin
          if (is_back && !btn_rd.long_done && age_pt >= 32'(lp_q)) begin
            btn_wr.long_done = 1'b1;
            if (!q_full) begin
              ev_we = 1'b1;
              ev_wr = '{kind: KIND_HOME, steps: 8'd0};
              head_d = head_nx;
            end
          end
        end else if (!isp && wp) begin
          if (active_q == 2'(idx_q)) begin
            if (age_pt < 32'(lp_q) && !q_full) begin
              ev_we = 1'b1;
              ev_wr = '{kind: is_back ? KIND_BACK : KIND_SELECT, steps: 8'd0};
              head_d = head_nx;
            end
            active_d = NoButton;
          end
          btn_wr.press_time = '0;
          btn_wr.pressed = 1'b0;
          btn_wr.long_done = 1'b0;
        end
      end
      ST_ENC: begin
        count_d = '0;
        if (active_q != NoButton) begin
          resid_d = '0;
        end else begin
          if (res_sum > 18'sd32767) resid_d = 16'sd32767;
          else if (res_sum < -18'sd32768) resid_d = -16'sd32768;
          else resid_d = 16'(res_sum);
          neg_d = resid_d[15];
          div_start = 1'b1;
          div_dvd = resid_d[15] ? 17'(-17'(resid_d)) : 17'(resid_d);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          resid_d = neg_q ? -16'(div_r) : 16'(div_r);
          mag = div_q;
          clamp_mag = (mag > 17'd127) ? 8'd127 : mag[7:0];
          if (mag != '0 && !q_full) begin
            ev_we = 1'b1;
            ev_wr = '{kind: KIND_ROTATE, steps: neg_q ? -clamp_mag : clamp_mag};
            head_d = head_nx;
          end
        end
      end
      ST_POLL: begin
        if (out_load) begin
          out_vd = 1'b1;
          if (q_empty) begin
            out_ev_d = 1'b0;
            out_kind_d = KIND_SELECT;
            out_steps_d = '0;
          end else begin
            out_ev_d = 1'b1;
            out_kind_d = ev_rd.kind;
            out_steps_d = ev_rd.steps;
            tail_d = tail_nx;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      prev_q   <= 2'd3;
      count_q  <= '0;
      resid_q  <= '0;
      active_q <= NoButton;
      bvld_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      out_vq   <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      prev_q   <= prev_d;
      count_q  <= count_d;
      resid_q  <= resid_d;
      active_q <= active_d;
      bvld_q   <= bvld_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      out_vq   <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      now_q <= in_ch.now_ms;
      lvl_q <= {in_ch.back_level, in_ch.confirm_level, in_ch.push_level};
    end
    neg_q       <= neg_d;
    out_ev_q    <= out_ev_d;
    out_kind_q  <= out_kind_d;
    out_steps_q <= out_steps_d;
  end

  assign out_ch.valid       = out_vq;
  assign out_ch.event_valid = out_ev_q;
  assign out_ch.event_kind  = out_kind_q;
  assign out_ch.event_steps = out_steps_q;

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_we |-> !q_full) else $error("event written into full ring");
  a_div_only_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> state_q == ST_DIV) else $error("divider started outside sequence");
  a_tail_on_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && !q_empty) |=> tail_q != $past(tail_q)) else $error("pop lost");
  a_btn_ram_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    btn_we |-> idx_q < BtnAw'(NumButtons)) else $error("button index out of range");
endmodule

/* tb/ui_encoder_button_event_unit_test.sv */
// Testbench for ui_encoder_button_event_unit: directed and random items checked
// against an in-bench predictor of encoder counting, debouncing and the event ring.
// Depends on ueb_pkg, ueb_if and the RTL of the block.
`timescale 1ns / 1ps

module ui_encoder_button_event_unit_test;
  import ueb_pkg::*;

  typedef struct packed {
    logic       ev_valid;
    logic [1:0] kind;
    logic [7:0] steps;
  } poll_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ueb_in_if  in_ch ();
  ueb_out_if out_ch ();
  ueb_cfg_if cfg_ch ();

  ui_encoder_button_event_unit u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state
  logic [15:0] m_debounce, m_long;
  logic        m_reverse;
  logic [4:0]  m_cpd;
  logic [1:0]  m_prev_ab;
  int          m_count, m_residual;
  logic        b_stable[3], b_flicker[3], b_pressed[3], b_long_done[3];
  logic [31:0] b_change[3], b_press[3];
  logic [1:0]  m_active;
  logic [1:0]  ring_kind[QueueDepth];
  logic [7:0]  ring_steps[QueueDepth];
  int          ring_head, ring_tail;

  poll_res_t   expected_polls[$];
  int          errors = 0;
  int          n_items = 0, n_polls = 0, n_events = 0;
  logic        rx_idle_en = 1'b1;
  logic        rx_hold = 1'b0;
  logic        tx_idle_en = 1'b1;
  int          quiet_cycles = 0;
  logic [31:0] now_ms = 0;

  function automatic int sat16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int enc_delta(logic [3:0] idx);
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14: return -1;
      4'd2, 4'd4, 4'd11, 4'd13: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic ring_push(logic [1:0] kind, int st);
    int nxt;
    nxt = (ring_head + 1) % QueueDepth;
    if (nxt != ring_tail) begin
      ring_kind[ring_head] = kind;
      ring_steps[ring_head] = st[7:0];
      ring_head = nxt;
    end
  endtask

  task automatic button_tick(int id, logic level, logic [31:0] t);
    logic was, isp;
    was = b_pressed[id];
    if (level != b_flicker[id]) begin
      b_flicker[id] = level;
      b_change[id] = t;
    end
    if (t - b_change[id] >= {16'd0, m_debounce}) b_stable[id] = b_flicker[id];
    isp = !b_stable[id];
    if (isp && !was) begin
      if (m_active == NoButton) begin
        m_active = id[1:0];
        b_press[id] = t;
        b_pressed[id] = 1'b1;
        b_long_done[id] = 1'b0;
      end
    end else if (isp && was && m_active == id[1:0]) begin
      if (id == 2 && !b_long_done[id] && t - b_press[id] >= {16'd0, m_long}) begin
        b_long_done[id] = 1'b1;
        ring_push(KIND_HOME, 0);
      end
    end else if (!isp && was) begin
      if (m_active == id[1:0]) begin
        if (t - b_press[id] < {16'd0, m_long})
          ring_push(id == 2 ? KIND_BACK : KIND_SELECT, 0);
        m_active = NoButton;
      end
      b_press[id] = 0;
      b_pressed[id] = 1'b0;
      b_long_done[id] = 1'b0;
    end
  endtask

  task automatic predict_item(logic [1:0] cmd, logic a, logic b, logic [31:0] t,
                              logic [2:0] lv);
    int taken, div, det;
    poll_res_t r;
    case (cmd)
      CMD_SAMPLE: begin
        m_count = sat16(m_count + enc_delta({m_prev_ab, a, b}));
        m_prev_ab = {a, b};
      end
      CMD_SERVICE: begin
        for (int i = 0; i < 3; i++) button_tick(i, lv[i], t);
        taken = m_count;
        m_count = 0;
        if (m_active != NoButton) m_residual = 0;
        else begin
          if (m_reverse) taken = -taken;
          m_residual = sat16(m_residual + taken);
          div = (m_cpd == 0) ? 1 : int'(m_cpd);
          det = m_residual / div;
          if (det != 0) begin
            m_residual -= det * div;
            if (det > 127) det = 127;
            if (det < -127) det = -127;
            ring_push(KIND_ROTATE, det);
          end
        end
      end
      CMD_POLL: begin
        if (ring_tail == ring_head) r = '0;
        else begin
          r = {1'b1, ring_kind[ring_tail], ring_steps[ring_tail]};
          ring_tail = (ring_tail + 1) % QueueDepth;
        end
        expected_polls.push_back(r);
      end
      default: ;
    endcase
  endtask

  // valid stays high after an accept so that a following item needs no second
  // assignment in the same time step; idling and settle() drop it
  task automatic send_item(logic [1:0] cmd, logic a, logic b, logic [31:0] t,
                           logic [2:0] lv);
    while (tx_idle_en && $urandom_range(99) < 10) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.enc_a <= a;
    in_ch.enc_b <= b;
    in_ch.now_ms <= t;
    in_ch.push_level <= lv[0];
    in_ch.confirm_level <= lv[1];
    in_ch.back_level <= lv[2];
    do @(posedge clk_i); while (!in_ch.ready);
    predict_item(cmd, a, b, t, lv);
    n_items++;
  endtask

  task automatic tick(logic [2:0] lv, int dt = 1);
    now_ms += dt;
    send_item(CMD_SERVICE, 1'b0, 1'b0, now_ms, lv);
  endtask

  task automatic poll();
    send_item(CMD_POLL, 1'b0, 1'b0, 32'd0, 3'b111);
  endtask

  task automatic write_reg(reg_e idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_DEBOUNCE: m_debounce = val;
      REG_LONG: m_long = val;
      REG_REVERSE: m_reverse = val[0];
      REG_CPD: m_cpd = val[4:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_polls.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic drain_ring();
    repeat (QueueDepth) poll();
  endtask

  task automatic rotate(int counts);
    logic [1:0] seq[4] = '{2'b11, 2'b10, 2'b00, 2'b01};
    int p;
    p = 0;
    for (int i = 0; i < 4; i++) if (seq[i] == m_prev_ab) p = i;
    for (int i = 0; i < (counts < 0 ? -counts : counts); i++) begin
      p = counts > 0 ? (p + 1) % 4 : (p + 3) % 4;
      send_item(CMD_SAMPLE, seq[p][1], seq[p][0], 32'd0, 3'b111);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    poll_res_t e;
    if (out_ch.valid && out_ch.ready) begin
      n_polls++;
      if (expected_polls.size() == 0) begin
        $display("%0t: unexpected result ev=%0b kind=%0d steps=%0d", $time,
                 out_ch.event_valid, out_ch.event_kind, out_ch.event_steps);
        errors++;
      end else begin
        e = expected_polls.pop_front();
        if (e.ev_valid) n_events++;
        if (out_ch.event_valid !== e.ev_valid || out_ch.event_kind !== e.kind ||
            out_ch.event_steps !== e.steps) begin
          $display("%0t: mismatch expected ev=%0b kind=%0d steps=%0d actual ev=%0b kind=%0d steps=%0d",
                   $time, e.ev_valid, e.kind, $signed(e.steps), out_ch.event_valid,
                   out_ch.event_kind, out_ch.event_steps);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= !rx_hold && !(rx_idle_en && $urandom_range(99) < 10);
  end

  // long receiver hold-off
  initial begin
    wait (n_items > 900);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rx_hold ||
        !rst_ni)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_directed();
    tick(3'b111);
    poll();
    rotate(4); tick(3'b111); poll();
    rotate(-9); tick(3'b111); poll(); rotate(1); tick(3'b111); poll();
    // illegal double transition and no-op command
    send_item(CMD_SAMPLE, ~m_prev_ab[1], ~m_prev_ab[0], 32'd0, 3'b111);
    send_item(CMD_NONE, 1'b1, 1'b1, 32'hFFFF_FFFF, 3'b000);
    tick(3'b111);
    // short push, confirm, back
    for (int i = 0; i < 3; i++) begin
      tick(~(3'b001 << i)); tick(~(3'b001 << i), 40);
      tick(3'b111, 5); tick(3'b111, 40); poll();
    end
    poll();
  endtask

  task automatic test_long_press();
    tick(3'b011); tick(3'b011, 40); tick(3'b011, 1100); tick(3'b011, 5);
    tick(3'b111); tick(3'b111, 40); poll(); poll();
    tick(3'b110); tick(3'b110, 40); tick(3'b100, 40); tick(3'b100, 1100);
    rotate(8); tick(3'b100);
    tick(3'b111); tick(3'b111, 40); poll(); poll();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < 12; i++) begin rotate(5); tick(3'b111); end
    drain_ring();
    rotate(200); tick(3'b111); drain_ring();
  endtask

  task automatic test_wrap();
    now_ms = 32'hFFFF_FFF0;
    tick(3'b110); tick(3'b110, 40); tick(3'b111, 4); tick(3'b111, 40);
    poll(); poll();
  endtask

  task automatic test_random(int n);
    logic [2:0] lv;
    int r;
    lv = 3'b111;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) lv[$urandom_range(2)] ^= 1'b1;
      if (r < 45) rotate($urandom_range(6) - 3);
      else if (r < 75) tick(lv, $urandom_range(3) == 0 ? $urandom_range(1500) : 
                              $urandom_range(40));
      else if (r < 97) poll();
      else if (r < 98) send_item(CMD_NONE, 1'($urandom), 1'($urandom), $urandom,
                                 3'($urandom));
      else send_item(CMD_SAMPLE, 1'($urandom), 1'($urandom), $urandom, 3'($urandom));
    end
    drain_ring();
  endtask

  initial begin
    in_ch.valid = 0; in_ch.command = CMD_NONE; in_ch.enc_a = 0; in_ch.enc_b = 0;
    in_ch.now_ms = 0; in_ch.push_level = 1; in_ch.confirm_level = 1; in_ch.back_level = 1;
    cfg_ch.valid = 0; cfg_ch.index = REG_DEBOUNCE; cfg_ch.data = 0;
    m_debounce = 30; m_long = 1000; m_reverse = 0; m_cpd = 4;
    m_prev_ab = 2'b11; m_count = 0; m_residual = 0; m_active = NoButton;
    for (int i = 0; i < 3; i++) begin
      b_stable[i] = 1; b_flicker[i] = 1; b_pressed[i] = 0; b_long_done[i] = 0;
      b_change[i] = 0; b_press[i] = 0;
    end
    ring_head = 0; ring_tail = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    settle();
    test_long_press();
    settle();
    write_reg(REG_CPD, 16'd1); write_reg(REG_REVERSE, 16'd1);
    write_reg(REG_DEBOUNCE, 16'd0); write_reg(REG_LONG, 16'd1);
    test_overflow();
    test_long_press();
    settle();
    write_reg(REG_CPD, 16'd0); write_reg(REG_REVERSE, 16'd0);
    test_overflow();
    settle();
    write_reg(REG_CPD, 16'd16); write_reg(REG_DEBOUNCE, 16'hFFFF);
    write_reg(REG_LONG, 16'hFFFF);
    test_wrap(); test_random(60);
    settle();
    write_reg(REG_CPD, 16'd31); write_reg(REG_DEBOUNCE, 16'd5); write_reg(REG_LONG, 16'd300);
    test_random(80);
    settle();
    write_reg(REG_CPD, 16'd4); write_reg(REG_DEBOUNCE, 16'd10); write_reg(REG_LONG, 16'd500);
    test_random(220);
    tx_idle_en = 1'b0; rx_idle_en = 1'b0;
    test_random(180);
    tx_idle_en = 1'b1; rx_idle_en = 1'b1;
    test_random(220);
    settle();

    $display("Covered %0d items, %0d polls with %0d events over several register settings.",
             n_items, n_polls, n_events);
    if (errors == 0 && expected_polls.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
